@@ src/price_level_order_book_top_assert.svh @@
`ifndef PRICE_LEVEL_ORDER_BOOK_TOP_ASSERT_SVH
`define PRICE_LEVEL_ORDER_BOOK_TOP_ASSERT_SVH

// same-cycle implication
`define PLOB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLOB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/plob_pkg.sv @@
package plob_pkg;

  localparam int MAX_LEVELS_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int PX_W     = 32;
  localparam int QTY_W    = 32;
  localparam int CFG_W    = 9;
  localparam int LVL_W    = 9;
  localparam int AVG_W    = 48;
  localparam int SPREAD_W = 33;
  localparam int LIQ_W    = 40;
  localparam int COST_W   = 64;

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 184;

  // output tdata field offsets
  localparam int O_AVG    = 0;
  localparam int O_NOLIQ  = 48;
  localparam int O_DROP   = 49;
  localparam int O_BIDLVL = 50;
  localparam int O_ASKLVL = 59;
  localparam int O_SPREAD = 68;
  localparam int O_BIDLIQ = 101;
  localparam int O_ASKLIQ = 141;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUOTE = 1'b1;
  localparam logic SIDE_BID  = 1'b0;
  localparam logic SIDE_ASK  = 1'b1;

  localparam logic [LIQ_W-1:0] LIQ_MAX = '1;

endpackage

@@ src/price_level_order_book_top.sv @@
// Price-level order book: bid levels held best (highest) first, ask levels best (lowest)
// first, each with an aggregated quantity. An add request merges into a level or inserts a
// new one; a quote request fills a quantity best price first and returns the average price
// with FRAC_BITS fraction bits. One request is handled at a time by a sequencer around a
// level memory with a read and a write port, registered reads, one 32x32 multiplier and a
// bit-serial divider. Per request: an add scans levels and shifts later ones on insert (or
// drops the new level if its side is full); a quote walks levels best first and then
// divides; every request then sums the best levels of both sides, up to liquidity_levels
// each (all when it is zero), for the liquidity totals. in_tready is high only while the
// block is idle; the result waits in an output register until taken.
module price_level_order_book_top import plob_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,     // liquidity_levels
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,        // price, quantity
  input  logic [IN_TUSER_W-1:0]  in_tuser,        // req_type, side
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // avg_price, no_liquidity, level_dropped, bid_levels, ask_levels, spread,
  // bid_liquidity, ask_liquidity, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int LW  = $clog2(MAX_LEVELS);
  localparam int CW  = $clog2(MAX_LEVELS + 1);
  localparam int LCW = (CW > CFG_W) ? CW : CFG_W;
  localparam int AW  = LW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_A_INS, S_A_SH, S_A_SHW,
    S_Q_RD, S_Q_MUL, S_Q_ACC, S_Q_DIV, S_L_RD, S_L_ACC, S_DONE
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0]  liq_r;
  logic [CW-1:0]     bid_cnt_r, ask_cnt_r;
  logic              s_r;
  logic [PX_W-1:0]   px_r;
  logic [QTY_W-1:0]  qty_r;
  logic [CW-1:0]     i_r, pos_r;
  logic [QTY_W-1:0]  rem_r;
  logic [COST_W-1:0] cost_r, prod_r;
  logic [AVG_W-1:0]  avg_r;
  logic              noliq_r, drop_r;
  logic [LIQ_W-1:0]  sum_r, bid_liq_r;
  logic [PX_W-1:0]   best_bid_r, best_ask_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_word;

  logic [PX_W-1:0]  px_mem  [2**AW];
  logic [QTY_W-1:0] qty_mem [2**AW];
  logic [PX_W-1:0]  rd_px_r;
  logic [QTY_W-1:0] rd_qty_r;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             we_px, we_qty;
  logic [PX_W-1:0]  wr_px;
  logic [QTY_W-1:0] wr_qty;

  logic [CW-1:0]     n_cur;
  logic [CW-1:0]     i_dec;
  logic              ranks;
  logic [QTY_W:0]    merge_sum;
  logic [QTY_W-1:0]  take;
  logic [LCW-1:0]    lim, liq_ext, n_ext;
  logic [LIQ_W:0]    liq_add;
  logic [LIQ_W-1:0]  liq_sat;
  logic              div_start, div_done;
  logic [AVG_W-1:0]  div_quot;
  logic [SPREAD_W-1:0] spread;
  logic [CW+LVL_W-1:0] bid_lvl_ext, ask_lvl_ext;

  assign n_cur     = s_r ? ask_cnt_r : bid_cnt_r;
  assign i_dec     = i_r - CW'(1);
  assign ranks     = (s_r == SIDE_BID) ? (rd_px_r > px_r) : (rd_px_r < px_r);
  assign merge_sum = {1'b0, rd_qty_r} + {1'b0, qty_r};
  assign take      = (rd_qty_r < rem_r) ? rd_qty_r : rem_r;
  assign liq_ext   = LCW'(liq_r);
  assign n_ext     = LCW'(n_cur);
  assign lim       = (liq_ext != '0 && liq_ext < n_ext) ? liq_ext : n_ext;
  assign liq_add   = {1'b0, sum_r} + (LIQ_W + 1)'(rd_qty_r);
  assign liq_sat   = liq_add[LIQ_W] ? LIQ_MAX : liq_add[LIQ_W-1:0];
  assign div_start = (state_r == S_Q_RD) && !(i_r < n_cur && rem_r != '0) && (rem_r == '0);
  assign spread    = {1'b0, best_ask_r} - {1'b0, best_bid_r};
  assign bid_lvl_ext = {{LVL_W{1'b0}}, bid_cnt_r};
  assign ask_lvl_ext = {{LVL_W{1'b0}}, ask_cnt_r};

  always_comb begin
    out_word = '0;
    out_word[O_AVG +: AVG_W]       = avg_r;
    out_word[O_NOLIQ]              = noliq_r;
    out_word[O_DROP]               = drop_r;
    out_word[O_BIDLVL +: LVL_W]    = bid_lvl_ext[LVL_W-1:0];
    out_word[O_ASKLVL +: LVL_W]    = ask_lvl_ext[LVL_W-1:0];
    out_word[O_SPREAD +: SPREAD_W] = spread;
    out_word[O_BIDLIQ +: LIQ_W]    = bid_liq_r;
    out_word[O_ASKLIQ +: LIQ_W]    = sum_r;
  end

  // memory port control
  always_comb begin
    rd_addr = {s_r, i_r[LW-1:0]};
    wr_addr = {s_r, i_r[LW-1:0]};
    we_px   = 1'b0;
    we_qty  = 1'b0;
    wr_px   = px_r;
    wr_qty  = qty_r;
    case (state_r)
      S_A_CHK: begin
        if (!ranks && rd_px_r == px_r) begin
          we_qty = 1'b1;
          wr_qty = merge_sum[QTY_W] ? '1 : merge_sum[QTY_W-1:0];
        end
      end
      S_A_SH: begin
        rd_addr = {s_r, i_dec[LW-1:0]};
        if (!(i_r > pos_r)) begin
          wr_addr = {s_r, pos_r[LW-1:0]};
          we_px   = 1'b1;
          we_qty  = 1'b1;
        end
      end
      S_A_SHW: begin
        we_px  = 1'b1;
        we_qty = 1'b1;
        wr_px  = rd_px_r;
        wr_qty = rd_qty_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_px) px_mem[wr_addr] <= wr_px;
    if (we_qty) qty_mem[wr_addr] <= wr_qty;
    rd_px_r  <= px_mem[rd_addr];
    rd_qty_r <= qty_mem[rd_addr];
  end

  plob_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .cost    (cost_r),
    .divisor (qty_r),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      liq_r       <= '0;
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) liq_r <= cfg_wr_data;
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            px_r    <= in_tdata[PX_W-1:0];
            qty_r   <= in_tdata[IN_TDATA_W-1:PX_W];
            rem_r   <= in_tdata[IN_TDATA_W-1:PX_W];
            i_r     <= '0;
            cost_r  <= '0;
            avg_r   <= '0;
            noliq_r <= 1'b0;
            drop_r  <= 1'b0;
            if (in_tuser[0] == REQ_ADD) begin
              s_r     <= in_tuser[1];
              state_r <= S_A_RD;
            end else if (in_tdata[IN_TDATA_W-1:PX_W] == '0) begin
              s_r     <= SIDE_BID;
              sum_r   <= '0;
              best_bid_r <= '0;
              state_r <= S_L_RD;
            end else begin
              s_r     <= in_tuser[1];
              state_r <= S_Q_RD;
            end
          end
        end
        S_A_RD: begin
          if (i_r < n_cur) begin
            state_r <= S_A_CHK;
          end else begin
            pos_r   <= i_r;
            state_r <= S_A_INS;
          end
        end
        S_A_CHK: begin
          if (ranks) begin
            i_r     <= i_r + CW'(1);
            state_r <= S_A_RD;
          end else if (rd_px_r == px_r) begin
            s_r     <= SIDE_BID;
            i_r     <= '0;
            sum_r   <= '0;
            best_bid_r <= '0;
            state_r <= S_L_RD;
          end else begin
            pos_r   <= i_r;
            state_r <= S_A_INS;
          end
        end
        S_A_INS: begin
          if (n_cur >= CW'(MAX_LEVELS)) begin
            drop_r  <= 1'b1;
            s_r     <= SIDE_BID;
            i_r     <= '0;
            sum_r   <= '0;
            best_bid_r <= '0;
            state_r <= S_L_RD;
          end else begin
            i_r     <= n_cur;
            state_r <= S_A_SH;
          end
        end
        S_A_SH: begin
          if (i_r > pos_r) begin
            state_r <= S_A_SHW;
          end else begin
            // new level written this cycle
            if (s_r == SIDE_BID) bid_cnt_r <= bid_cnt_r + CW'(1);
            else ask_cnt_r <= ask_cnt_r + CW'(1);
            s_r     <= SIDE_BID;
            i_r     <= '0;
            sum_r   <= '0;
            best_bid_r <= '0;
            state_r <= S_L_RD;
          end
        end
        S_A_SHW: begin
          i_r     <= i_dec;
          state_r <= S_A_SH;
        end
        S_Q_RD: begin
          if (i_r < n_cur && rem_r != '0) begin
            state_r <= S_Q_MUL;
          end else if (rem_r != '0) begin
            noliq_r <= 1'b1;
            s_r     <= SIDE_BID;
            i_r     <= '0;
            sum_r   <= '0;
            best_bid_r <= '0;
            state_r <= S_L_RD;
          end else begin
            state_r <= S_Q_DIV;
          end
        end
        S_Q_MUL: begin
          prod_r  <= take * rd_px_r;
          rem_r   <= rem_r - take;
          state_r <= S_Q_ACC;
        end
        S_Q_ACC: begin
          cost_r  <= cost_r + prod_r;
          i_r     <= i_r + CW'(1);
          state_r <= S_Q_RD;
        end
        S_Q_DIV: begin
          if (div_done) begin
            avg_r   <= div_quot;
            s_r     <= SIDE_BID;
            i_r     <= '0;
            sum_r   <= '0;
            best_bid_r <= '0;
            state_r <= S_L_RD;
          end
        end
        S_L_RD: begin
          if (LCW'(i_r) < lim) begin
            state_r <= S_L_ACC;
          end else if (s_r == SIDE_BID) begin
            bid_liq_r  <= sum_r;
            sum_r      <= '0;
            s_r        <= SIDE_ASK;
            i_r        <= '0;
            best_ask_r <= '0;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_L_ACC: begin
          // best price comes from the first level read
          if (i_r == '0) begin
            if (s_r == SIDE_BID) best_bid_r <= rd_px_r;
            else best_ask_r <= rd_px_r;
          end
          sum_r   <= liq_sat;
          i_r     <= i_r + CW'(1);
          state_r <= S_L_RD;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= out_word;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ src/plob_div.sv @@
module plob_div import plob_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [COST_W-1:0] cost,
  input  logic [QTY_W-1:0]  divisor,
  output logic              done,
  output logic [AVG_W-1:0]  quot
);

  localparam int DW  = COST_W + FRAC_BITS;
  localparam int CNW = $clog2(DW + 1);

  logic [DW-1:0]    dvd_r;
  logic [QTY_W-1:0] rem_r;
  logic [QTY_W-1:0] dsr_r;
  logic [AVG_W-1:0] quot_r;
  logic [CNW-1:0]   cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [QTY_W:0]   rem_sh;
  logic [QTY_W:0]   rem_sub;
  logic             fits;

  // one quotient bit a cycle, restoring
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign fits    = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= {cost, {FRAC_BITS{1'b0}}};
        dsr_r  <= divisor;
        rem_r  <= '0;
        quot_r <= '0;
        cnt_r  <= CNW'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dvd_r  <= {dvd_r[DW-2:0], 1'b0};
        rem_r  <= fits ? rem_sub[QTY_W-1:0] : rem_sh[QTY_W-1:0];
        quot_r <= {quot_r[AVG_W-2:0], fits};
        cnt_r  <= cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

@@ src/plob_checker.sv @@
`include "price_level_order_book_top_assert.svh"

module plob_checker import plob_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [IN_TUSER_W-1:0]  in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // one request at a time
  `PLOB_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "ready after request")

  `PLOB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "stalled result changed")

  `PLOB_ASSERT_NOW(a_flags_excl, out_tvalid,
                   !(out_tdata[O_NOLIQ] && out_tdata[O_DROP]), "both flags set")

  // a short fill reports price zero
  `PLOB_ASSERT_NOW(a_noliq_zero, out_tvalid && out_tdata[O_NOLIQ],
                   out_tdata[O_AVG +: AVG_W] == '0, "short fill with price")

endmodule

bind price_level_order_book_top plob_checker u_plob_checker (.*);
